// File: hdl/maepf_pkg.sv
// Package for the median burst pressure filter with adaptive smoothing.
// Holds field widths, register indexes, reset defaults, error sign codes
// and the sequencer state type. No dependencies.
package maepf_pkg;

  localparam int unsigned SAMPLE_W  = 23;
  localparam int unsigned OFFSET_W  = 22;
  localparam int unsigned PRESS_W   = 24;
  localparam int unsigned ALPHA_W   = 17;
  localparam int unsigned CNT_REG_W = 5;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MUL_W     = 24;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned FRAC_W    = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_COUNT    = 3'd0,
    CFG_OFFSET_VOLTAGE  = 3'd1,
    CFG_PRESSURE_GAIN   = 3'd2,
    CFG_FILTER_ENABLE   = 3'd3,
    CFG_ALPHA_MIN       = 3'd4,
    CFG_ALPHA_MAX       = 3'd5,
    CFG_DELTA_REF       = 3'd6,
    CFG_JITTER_DEADBAND = 3'd7
  } cfg_idx_e;

  // reset defaults, also the fallbacks for invalid settings
  localparam logic [CNT_REG_W-1:0] DEF_SAMPLE_COUNT = 5'd5;
  localparam logic [OFFSET_W-1:0]  DEF_OFFSET       = 22'd32768;
  localparam logic [PRESS_W-1:0]   DEF_GAIN         = 24'd1638400;
  localparam logic [ALPHA_W-1:0]   DEF_ALPHA_MIN    = 17'd3277;
  localparam logic [ALPHA_W-1:0]   DEF_ALPHA_MAX    = 17'd39322;
  localparam logic [PRESS_W-1:0]   DEF_DELTA_REF    = 24'd65536;
  localparam logic [PRESS_W-1:0]   DEF_DEADBAND     = 24'd6554;

  localparam logic [ALPHA_W-1:0]   ONE_Q16          = 17'd65536;
  localparam logic [ALPHA_W-1:0]   HUNDREDTH_Q16    = 17'd655;
  localparam logic [PRESS_W-1:0]   PRESS_MAX        = 24'hFFFFFF;

  // sign of the last filter error
  typedef enum logic [1:0] {
    SGN_NONE = 2'd0,
    SGN_POS  = 2'd1,
    SGN_NEG  = 2'd2
  } err_sign_e;

  // sequencer states, one-hot
  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_LOAD  = 14'b00000000000010,
    ST_CMP   = 14'b00000000000100,
    ST_PMUL  = 14'b00000000001000,
    ST_PSAT  = 14'b00000000010000,
    ST_ERR   = 14'b00000000100000,
    ST_FDIV  = 14'b00000001000000,
    ST_FLOOR = 14'b00000010000000,
    ST_RDIV  = 14'b00000100000000,
    ST_SQ    = 14'b00001000000000,
    ST_AMUL  = 14'b00010000000000,
    ST_SMUL  = 14'b00100000000000,
    ST_UPD   = 14'b01000000000000,
    ST_DONE  = 14'b10000000000000
  } state_e;

endpackage

// File: hdl/median_adaptive_ema_pressure_filter.sv
// Median burst pressure filter with adaptive exponential smoothing.
// Depends on maepf_pkg (widths, register indexes, defaults, states).
//
//  channel  handshake                 payload
//  -------  ------------------------  ------------------------------------------
//  in       in_valid_i / in_stall_o   sample_voltage_i, valve_open_i, source_select_i
//  out      out_valid_o / out_stall_i median_voltage_o, pressure_o
//  cfg      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// A sample that does not end a burst is stored while idle. At burst end the
// median is found by a rank search on one shared comparator, then pressure
// and smoothing are computed on one shared 24x24 multiplier and one
// bit-serial divider.
// Reset clears all control and filter state and loads the register defaults.
// in_stall_o is high while a burst end is processed; a pending result waits
// in the output register while new samples are taken.
module median_adaptive_ema_pressure_filter #(
  parameter int unsigned MAX_SAMPLES = 15,
  parameter int unsigned MIN_SAMPLES = 3,
  parameter int unsigned TREND_LIMIT = 40
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [maepf_pkg::SAMPLE_W-1:0] sample_voltage_i,
  input  logic                                  valve_open_i,
  input  logic                                  source_select_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [maepf_pkg::SAMPLE_W-1:0] median_voltage_o,
  output logic        [maepf_pkg::PRESS_W-1:0]  pressure_o,
  input  logic                                  cfg_we_i,
  input  logic        [maepf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic        [maepf_pkg::CFG_W-1:0]    cfg_wdata_i
);

  localparam int unsigned IDX_W     = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W     = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned TREND_W   = $clog2(TREND_LIMIT + 1);
  localparam int unsigned TREND_DIV = 10 * TREND_LIMIT;
  localparam int unsigned SW        = maepf_pkg::SAMPLE_W;
  localparam int unsigned PW        = maepf_pkg::PRESS_W;
  localparam int unsigned AW        = maepf_pkg::ALPHA_W;
  localparam int unsigned MW        = maepf_pkg::MUL_W;
  localparam int unsigned FW        = maepf_pkg::FRAC_W;
  localparam logic [4:0] MIN5 = 5'(MIN_SAMPLES);
  localparam logic [4:0] MAX5 = 5'(MAX_SAMPLES);
  localparam logic [TREND_W-1:0] TREND_MAX = TREND_W'(TREND_LIMIT);
  // trend * 65536 / TREND_DIV as a reciprocal multiply, exact for every trend
  localparam int unsigned TREND_SH = $clog2(10 * TREND_LIMIT * TREND_LIMIT + 1);
  localparam longint unsigned TREND_RCP =
      ((64'd1 << (FW + TREND_SH)) + 64'(TREND_DIV) - 64'd1) / 64'(TREND_DIV);
  localparam logic [MW-1:0] TREND_RCP_W = MW'(TREND_RCP);

  // configuration registers
  logic [4:0]    sample_count_q;
  logic [21:0]   offset_q;
  logic [PW-1:0] gain_q;
  logic          enable_q;
  logic [AW-1:0] amin_q, amax_q;
  logic [PW-1:0] dref_q, dead_q;

  // control state
  maepf_pkg::state_e    state_q, state_d;
  logic [IDX_W-1:0]     sidx_q, sidx_d;
  logic                 out_valid_q, out_valid_d;
  logic                 primed_q, primed_d;
  maepf_pkg::err_sign_e sign_q, sign_d;
  logic [TREND_W-1:0]   trend_q, trend_d;
  logic                 src_q, src_d;
  logic                 known_q, known_d;
  logic [PW-1:0]        filt_q, filt_d;

  // payload and working registers
  logic signed [SW-1:0] store_q [MAX_SAMPLES];
  logic signed [SW-1:0] cand_q, cand_d, med_q, med_d, out_med_q;
  logic [IDX_W-1:0]     i_q, i_d, j_q, j_d;
  logic [CNT_W-1:0]     rank_q, rank_d, n_q, n_d;
  logic                 valve_q, valve_d, neg_q, neg_d;
  logic [PW-1:0]        p_q, p_d, mag_q, mag_d, res_q, res_d, out_press_q;
  logic [AW-1:0]        floor_q, floor_d, ratio_q, ratio_d;
  logic [PW-1:0]        rem_q, rem_d, den_q, den_d;
  logic [FW-1:0]        quo_q, quo_d;
  logic [3:0]           dcnt_q, dcnt_d;
  logic [2*MW-1:0]      prod_q;
  logic [MW-1:0]        mul_a, mul_b;

  logic                 in_acc, out_load, store_we;
  logic [IDX_W-1:0]     slot, rd_idx;
  logic signed [SW-1:0] rd_val;

  // effective settings after validity checks
  logic [AW-1:0] amin_e, amax_e;
  logic [PW-1:0] dref_e, dead_e;
  always_comb begin
    amin_e = amin_q;
    amax_e = amax_q;
    if (amin_q == '0 || amin_q >= maepf_pkg::ONE_Q16) begin
      amin_e = maepf_pkg::DEF_ALPHA_MIN;
    end
    if (amax_q == '0 || amax_q > maepf_pkg::ONE_Q16) begin
      amax_e = maepf_pkg::DEF_ALPHA_MAX;
    end
    if (amin_e >= amax_e) begin
      amin_e = maepf_pkg::DEF_ALPHA_MIN;
      amax_e = maepf_pkg::DEF_ALPHA_MAX;
    end
    dref_e = (dref_q <= PW'(maepf_pkg::HUNDREDTH_Q16)) ? maepf_pkg::DEF_DELTA_REF : dref_q;
    dead_e = (dead_q >= dref_e) ? maepf_pkg::DEF_DEADBAND : dead_q;
  end

  // burst length: clamped, then made odd within the maximum
  logic [4:0]       blen5;
  logic [CNT_W-1:0] blen, blen_m1;
  always_comb begin
    blen5 = sample_count_q;
    if (blen5 < MIN5) blen5 = MIN5;
    if (blen5 > MAX5) blen5 = MAX5;
    if (!blen5[0] && blen5 != MAX5) blen5 = blen5 + 5'd1;
    blen    = CNT_W'(blen5);
    blen_m1 = blen - CNT_W'(1);
    slot    = (CNT_W'(sidx_q) < blen_m1) ? sidx_q : IDX_W'(blen_m1);
  end

  assign in_stall_o = (state_q != maepf_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign store_we   = in_acc;

  // single read port of the sample store
  assign rd_idx = (state_q == maepf_pkg::ST_LOAD) ? i_q : j_q;
  assign rd_val = store_q[rd_idx];

  // rank compare for the median search
  logic             less;
  logic [CNT_W-1:0] rank_nx;
  assign less    = (rd_val < cand_q) || (rd_val == cand_q && j_q < i_q);
  assign rank_nx = rank_q + CNT_W'(less);

  // pressure from the product of (median - offset) and gain
  logic signed [SW:0] vdiff;
  logic [PW-1:0]      p_w;
  assign vdiff = SW'(0) + (SW+1)'(med_q) - $signed({2'b00, offset_q});
  assign p_w   = (|prod_q[2*MW-1:PW+FW]) ? maepf_pkg::PRESS_MAX : prod_q[PW+FW-1:FW];

  // filter error
  logic signed [PW:0] err;
  logic [PW-1:0]      err_mag;
  assign err     = $signed({1'b0, p_q}) - $signed({1'b0, filt_q});
  assign err_mag = err[PW] ? PW'(-err) : err[PW-1:0];

  // adaptation ratio operands
  logic signed [PW+1:0] num, den;
  logic [PW-1:0]        num_abs, den_abs;
  assign num     = $signed({2'b00, mag_q}) - $signed({2'b00, dead_e});
  assign den     = $signed({2'b00, dref_e}) - $signed({2'b00, dead_e});
  assign num_abs = num[PW+1] ? PW'(-num) : num[PW-1:0];
  assign den_abs = den[PW+1] ? PW'(-den) : den[PW-1:0];

  // alpha floor from trend quotient
  logic [FW-1:0]        trend_quo;
  logic [AW:0]        floor_sum;
  logic signed [AW+1:0] floor_cap;
  assign trend_quo = prod_q[TREND_SH +: FW];
  assign floor_sum = {1'b0, amin_e} + (AW+1)'(trend_quo);
  assign floor_cap = $signed({2'b00, amax_e}) - $signed({2'b00, maepf_pkg::HUNDREDTH_Q16});

  // divider step: one quotient bit of rem / den per cycle
  logic [PW:0]   div_sh;
  logic          div_ge;
  logic [PW-1:0] div_rem;
  logic [FW-1:0] div_quo;
  assign div_sh  = {rem_q, 1'b0};
  assign div_ge  = div_sh >= {1'b0, den_q};
  assign div_rem = div_ge ? PW'(div_sh - {1'b0, den_q}) : div_sh[PW-1:0];
  assign div_quo = {quo_q[FW-2:0], div_ge};

  // filter update
  logic [AW-1:0]        alpha;
  logic [PW-1:0]        step;
  logic signed [PW+1:0] fnew;
  assign alpha = AW'({1'b0, floor_q} + (AW+1)'(prod_q[AW+FW-1:FW]));
  assign step  = prod_q[PW+FW-1:FW];
  assign fnew  = neg_q ? ($signed({2'b00, filt_q}) - $signed({2'b00, step}))
                       : ($signed({2'b00, filt_q}) + $signed({2'b00, step}));

  // sequencer
  always_comb begin
    state_d   = state_q;
    sidx_d    = sidx_q;
    primed_d  = primed_q;
    sign_d    = sign_q;
    trend_d   = trend_q;
    src_d     = src_q;
    known_d   = known_q;
    filt_d    = filt_q;
    cand_d    = cand_q;
    med_d     = med_q;
    i_d       = i_q;
    j_d       = j_q;
    rank_d    = rank_q;
    n_d       = n_q;
    valve_d   = valve_q;
    neg_d     = neg_q;
    p_d       = p_q;
    mag_d     = mag_q;
    res_d     = res_q;
    floor_d   = floor_q;
    ratio_d   = ratio_q;
    rem_d     = rem_q;
    den_d     = den_q;
    quo_d     = quo_q;
    dcnt_d    = dcnt_q;
    mul_a     = '0;
    mul_b     = '0;
    out_load  = 1'b0;
    unique case (state_q)
      maepf_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (CNT_W'(slot) == blen_m1) begin
            sidx_d  = '0;
            n_d     = blen;
            valve_d = valve_open_i;
            i_d     = '0;
            if (!known_q || src_q != source_select_i) begin
              primed_d = 1'b0;
              filt_d   = '0;
              sign_d   = maepf_pkg::SGN_NONE;
              trend_d  = '0;
              src_d    = source_select_i;
              known_d  = 1'b1;
            end
            state_d = maepf_pkg::ST_LOAD;
          end else begin
            sidx_d = slot + IDX_W'(1);
          end
        end
      end
      maepf_pkg::ST_LOAD: begin
        cand_d  = rd_val;
        j_d     = '0;
        rank_d  = '0;
        state_d = maepf_pkg::ST_CMP;
      end
      maepf_pkg::ST_CMP: begin
        rank_d = rank_nx;
        if (CNT_W'(j_q) == n_q - CNT_W'(1)) begin
          if (rank_nx == (n_q >> 1)) begin
            med_d   = cand_q;
            state_d = maepf_pkg::ST_PMUL;
          end else begin
            i_d     = i_q + IDX_W'(1);
            state_d = maepf_pkg::ST_LOAD;
          end
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      maepf_pkg::ST_PMUL: begin
        mul_a   = (vdiff > 0) ? MW'(vdiff[SW-2:0]) : '0;
        mul_b   = gain_q;
        state_d = maepf_pkg::ST_PSAT;
      end
      maepf_pkg::ST_PSAT: begin
        p_d   = p_w;
        res_d = p_w;
        priority if (!enable_q) begin
          primed_d = 1'b0;
          filt_d   = '0;
          sign_d   = maepf_pkg::SGN_NONE;
          trend_d  = '0;
          state_d  = maepf_pkg::ST_DONE;
        end else if (valve_q || !primed_q) begin
          // open valve drops priming; an unprimed filter takes the pressure
          primed_d = !valve_q;
          if (!valve_q) filt_d = p_w;
          sign_d   = maepf_pkg::SGN_NONE;
          trend_d  = '0;
          state_d  = maepf_pkg::ST_DONE;
        end else begin
          state_d = maepf_pkg::ST_ERR;
        end
      end
      maepf_pkg::ST_ERR: begin
        mag_d = err_mag;
        neg_d = err[PW];
        if (err_mag > dead_e && err != 0 &&
            ((err[PW] && sign_q == maepf_pkg::SGN_NEG) ||
             (!err[PW] && sign_q == maepf_pkg::SGN_POS))) begin
          if (trend_q < TREND_MAX) trend_d = trend_q + TREND_W'(1);
        end else if (err_mag > dead_e) begin
          trend_d = TREND_W'(1);
        end else if (trend_q != '0) begin
          trend_d = trend_q - TREND_W'(1);
        end
        sign_d = (err == 0) ? maepf_pkg::SGN_NONE
               : (err[PW] ? maepf_pkg::SGN_NEG : maepf_pkg::SGN_POS);
        state_d = maepf_pkg::ST_FDIV;
      end
      // trend share of the floor by reciprocal multiply
      maepf_pkg::ST_FDIV: begin
        mul_a   = MW'(trend_q);
        mul_b   = TREND_RCP_W;
        state_d = maepf_pkg::ST_FLOOR;
      end
      maepf_pkg::ST_RDIV: begin
        rem_d  = div_rem;
        quo_d  = div_quo;
        dcnt_d = dcnt_q + 4'd1;
        if (dcnt_q == 4'd15) begin
          ratio_d = AW'(div_quo);
          state_d = maepf_pkg::ST_SQ;
        end
      end
      maepf_pkg::ST_FLOOR: begin
        if (floor_sum >= {1'b0, amax_e}) begin
          floor_d = floor_cap[AW+1] ? '0 : floor_cap[AW-1:0];
        end else begin
          floor_d = floor_sum[AW-1:0];
        end
        state_d = maepf_pkg::ST_SQ;
        if (den == 0) begin
          ratio_d = (num > 0) ? maepf_pkg::ONE_Q16 : '0;
        end else if ((num > 0 && den > 0) || (num < 0 && den < 0)) begin
          if (num_abs >= den_abs) begin
            ratio_d = maepf_pkg::ONE_Q16;
          end else begin
            rem_d   = num_abs;
            den_d   = den_abs;
            quo_d   = '0;
            dcnt_d  = '0;
            state_d = maepf_pkg::ST_RDIV;
          end
        end else begin
          ratio_d = '0;
        end
      end
      maepf_pkg::ST_SQ: begin
        mul_a   = MW'(ratio_q);
        mul_b   = MW'(ratio_q);
        state_d = maepf_pkg::ST_AMUL;
      end
      maepf_pkg::ST_AMUL: begin
        mul_a   = MW'(amax_e - floor_q);
        mul_b   = MW'(prod_q[AW+FW-1:FW]);
        state_d = maepf_pkg::ST_SMUL;
      end
      maepf_pkg::ST_SMUL: begin
        mul_a   = MW'(alpha);
        mul_b   = mag_q;
        state_d = maepf_pkg::ST_UPD;
      end
      maepf_pkg::ST_UPD: begin
        priority if (fnew < 0) begin
          filt_d = '0;
        end else if (fnew > $signed({2'b00, maepf_pkg::PRESS_MAX})) begin
          filt_d = maepf_pkg::PRESS_MAX;
        end else begin
          filt_d = fnew[PW-1:0];
        end
        res_d   = filt_d;
        state_d = maepf_pkg::ST_DONE;
      end
      maepf_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = maepf_pkg::ST_IDLE;
        end
      end
      default: state_d = maepf_pkg::ST_IDLE;
    endcase
  end

  // output word handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= maepf_pkg::ST_IDLE;
      sidx_q      <= '0;
      out_valid_q <= 1'b0;
      primed_q    <= 1'b0;
      sign_q      <= maepf_pkg::SGN_NONE;
      trend_q     <= '0;
      src_q       <= 1'b0;
      known_q     <= 1'b0;
      filt_q      <= '0;
    end else begin
      state_q     <= state_d;
      sidx_q      <= sidx_d;
      out_valid_q <= out_valid_d;
      primed_q    <= primed_d;
      sign_q      <= sign_d;
      trend_q     <= trend_d;
      src_q       <= src_d;
      known_q     <= known_d;
      filt_q      <= filt_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= maepf_pkg::DEF_SAMPLE_COUNT;
      offset_q       <= maepf_pkg::DEF_OFFSET;
      gain_q         <= maepf_pkg::DEF_GAIN;
      enable_q       <= 1'b1;
      amin_q         <= maepf_pkg::DEF_ALPHA_MIN;
      amax_q         <= maepf_pkg::DEF_ALPHA_MAX;
      dref_q         <= maepf_pkg::DEF_DELTA_REF;
      dead_q         <= maepf_pkg::DEF_DEADBAND;
    end else if (cfg_we_i) begin
      unique case (maepf_pkg::cfg_idx_e'(cfg_idx_i))
        maepf_pkg::CFG_SAMPLE_COUNT:    sample_count_q <= cfg_wdata_i[4:0];
        maepf_pkg::CFG_OFFSET_VOLTAGE:  offset_q       <= cfg_wdata_i[21:0];
        maepf_pkg::CFG_PRESSURE_GAIN:   gain_q         <= cfg_wdata_i;
        maepf_pkg::CFG_FILTER_ENABLE:   enable_q       <= cfg_wdata_i[0];
        maepf_pkg::CFG_ALPHA_MIN:       amin_q         <= cfg_wdata_i[AW-1:0];
        maepf_pkg::CFG_ALPHA_MAX:       amax_q         <= cfg_wdata_i[AW-1:0];
        maepf_pkg::CFG_DELTA_REF:       dref_q         <= cfg_wdata_i;
        maepf_pkg::CFG_JITTER_DEADBAND: dead_q         <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sample store
  always_ff @(posedge clk_i) begin
    if (store_we) store_q[slot] <= sample_voltage_i;
  end

  // working and payload registers, shared multiplier
  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    med_q   <= med_d;
    i_q     <= i_d;
    j_q     <= j_d;
    rank_q  <= rank_d;
    n_q     <= n_d;
    valve_q <= valve_d;
    neg_q   <= neg_d;
    p_q     <= p_d;
    mag_q   <= mag_d;
    res_q   <= res_d;
    floor_q <= floor_d;
    ratio_q <= ratio_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    quo_q   <= quo_d;
    dcnt_q  <= dcnt_d;
    prod_q  <= mul_a * mul_b;
    if (out_load) begin
      out_med_q   <= med_q;
      out_press_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_voltage_o = out_med_q;
  assign pressure_o       = out_press_q;

endmodule
